// ===== rtl/utf8_cp1251_to_ucs2_decoder_top_defines.svh =====
// Assertion macros shared by the decoder checker.
`ifndef UTF8_CP1251_TO_UCS2_DECODER_TOP_DEFINES_SVH
`define UTF8_CP1251_TO_UCS2_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8CP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8CP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u8cp_pkg.sv =====
// Shared types, constants and the Windows-1251 table for the decoder.
package u8cp_pkg;

  localparam int unsigned CountWidth = 24;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    logic [1:0]            pending;
    logic [9:0]            partial;
    logic                  err;
    logic                  term;
    logic [CountWidth-1:0] count;
  } u8cp_state_t;

  // One result request
  typedef struct packed {
    logic [15:0]           code_unit;
    logic                  char_valid;
    logic                  decode_error;
    logic                  text_done;
    logic [CountWidth-1:0] char_count;
  } u8cp_result_t;

  // Windows-1251 upper half, indexed by byte - 0x80
  localparam logic [15:0] Cp1251Rom [128] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h003F, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
    16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
    16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
    16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
    16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
    16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
    16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
    16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
  };

endpackage

// ===== rtl/utf8_cp1251_to_ucs2_decoder_top.sv =====
// Top level of the UTF-8 / Windows-1251 to 16-bit code unit decoder.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | data_byte_i, end_of_text_i
//  out     | output    | out_valid_o/out_ready_i | code_unit_o .. char_count_o (5 fields)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (encoding_mode)
//
// One byte per clock sustained while the output is not stalled; an accepted byte is
// decoded from the input register into the result register.
// The rate is set by the combinational state update of the per-byte decoder.
// Reset clears the mode, the decode state and both valid flags; no clearing pass.
// A stalled result holds in the result register while the next byte waits in
// the input register; the configuration port is always ready.
module utf8_cp1251_to_ucs2_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        char_valid_o,
  output logic        decode_error_o,
  output logic        text_done_o,
  output logic [23:0] char_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   in_end_q;
  logic                   mode_q;
  u8cp_pkg::u8cp_state_t  state_q;
  u8cp_pkg::u8cp_state_t  state_d;
  logic                   out_valid_q;
  u8cp_pkg::u8cp_result_t out_q;
  u8cp_pkg::u8cp_result_t res_d;
  logic                   res_valid_d;
  logic                   advance;
  logic                   cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  u8cp_step u_step (
    .state_i       (state_q),
    .mode_i        (mode_q),
    .data_byte_i   (in_byte_q),
    .end_of_text_i (in_end_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid_d),
    .res_o         (res_d)
  );

  // Input register: take a request whenever the slot frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= end_of_text_i;
    end
  end

  // Mode register and decode state; a mode write drops any open sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      state_q <= '0;
    end else if (cfg_write) begin
      mode_q          <= cfg_data_i;
      state_q.pending <= '0;
      state_q.partial <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load a decoded request, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_unit_o    = out_q.code_unit;
  assign char_valid_o   = out_q.char_valid;
  assign decode_error_o = out_q.decode_error;
  assign text_done_o    = out_q.text_done;
  assign char_count_o   = out_q.char_count;

endmodule

// ===== rtl/u8cp_step.sv =====
// Per-byte decode logic: next state and result request for one byte.
module u8cp_step (
  input  u8cp_pkg::u8cp_state_t  state_i,
  input  logic                   mode_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_text_i,
  output u8cp_pkg::u8cp_state_t  state_o,
  output logic                   res_valid_o,
  output u8cp_pkg::u8cp_result_t res_o
);

  logic [1:0]  pend;
  logic [9:0]  part;
  logic        err;
  logic [23:0] cnt;
  logic        endf;
  logic        have;
  logic [15:0] code;
  logic [7:0]  low;
  logic        cont;

  always_comb begin
    pend = state_i.pending;
    part = state_i.partial;
    err  = state_i.err;
    cnt  = state_i.count;
    endf = end_of_text_i;
    have = 1'b0;
    code = '0;
    low  = data_byte_i ^ 8'h80;
    cont = (data_byte_i[7:6] == 2'b10);

    // Open a new text after the previous one ended
    if (state_i.term) begin
      pend = '0;
      part = '0;
      err  = 1'b0;
      cnt  = '0;
    end

    if (data_byte_i == 8'h00) begin
      endf = 1'b1;
    end else if (!err) begin
      if (mode_i) begin
        // Windows-1251: lower half passes, upper half through the table
        pend = '0;
        part = '0;
        have = 1'b1;
        if (data_byte_i[7]) begin
          code = u8cp_pkg::Cp1251Rom[data_byte_i[6:0]];
        end else begin
          code = {8'h00, data_byte_i};
        end
      end else if (pend == 2'd0) begin
        // Lead byte
        case (data_byte_i) inside
          [8'h01:8'h7F]: begin
            code = {8'h00, data_byte_i};
            have = 1'b1;
          end
          [8'hC2:8'hDF]: begin
            part = {5'b0, data_byte_i[4:0]};
            pend = 2'd1;
          end
          [8'hE0:8'hEF]: begin
            part = {6'b0, data_byte_i[3:0]};
            pend = 2'd2;
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end else if (pend == 2'd1 && cont) begin
        // Final continuation byte completes the character
        code = {part, low[5:0]};
        have = 1'b1;
        pend = '0;
        part = '0;
      end else if (pend == 2'd2 && cont && (part != '0 || data_byte_i >= 8'hA0)) begin
        // Middle byte of a three-byte form; an E0 lead needs A0 or above
        part = {part[3:0], low[5:0]};
        pend = 2'd1;
      end else begin
        err  = 1'b1;
        pend = '0;
        part = '0;
      end
    end

    // Flag a sequence cut off by the end of the text
    if (endf && pend != 2'd0) begin
      err  = 1'b1;
      pend = '0;
      part = '0;
    end

    // Saturating character count
    if (have && cnt != u8cp_pkg::CountMax) begin
      cnt = cnt + 24'd1;
    end

    state_o.pending = pend;
    state_o.partial = part;
    state_o.err     = err;
    state_o.term    = endf;
    state_o.count   = cnt;

    res_valid_o         = have || endf;
    res_o.code_unit     = have ? code : 16'h0000;
    res_o.char_valid    = have;
    res_o.decode_error  = endf && err;
    res_o.text_done     = endf;
    res_o.char_count    = cnt;
  end

endmodule

// ===== rtl/u8cp_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
`include "utf8_cp1251_to_ucs2_decoder_top_defines.svh"

module u8cp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] code_unit_o,
  input logic        char_valid_o,
  input logic        decode_error_o,
  input logic        text_done_o,
  input logic [23:0] char_count_o
);

  // Hold a stalled result request
  `U8CP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(code_unit_o) && $stable(char_count_o), "stalled result changed")

  // A result without a character must end the text
  `U8CP_ASSERT_IMPLY(a_empty_is_end, clk_i, rst_ni, out_valid_o && !char_valid_o, text_done_o && code_unit_o == 16'h0000, "empty result not at end of text")

  // Errors are reported only on the final result
  `U8CP_ASSERT_IMPLY(a_err_at_end, clk_i, rst_ni, out_valid_o && decode_error_o, text_done_o, "error outside final result")

  // A delivered character is always counted
  `U8CP_ASSERT_IMPLY(a_count_nonzero, clk_i, rst_ni, out_valid_o && char_valid_o, char_count_o != 24'd0, "character with zero count")

endmodule

bind utf8_cp1251_to_ucs2_decoder_top u8cp_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .code_unit_o    (code_unit_o),
  .char_valid_o   (char_valid_o),
  .decode_error_o (decode_error_o),
  .text_done_o    (text_done_o),
  .char_count_o   (char_count_o)
);
